// ===== hdl/mle_pkg.sv =====
// shared types, constants and letter tables for the morse letter encoder
package mle_pkg;

    localparam int UNIT_W = 4;
    localparam int CHAR_W = 8;
    localparam int SEG_W  = 3;
    localparam int REG_W  = 2;

    typedef enum logic [REG_W-1:0] {
        REG_DOT        = 2'd0,
        REG_DASH       = 2'd1,
        REG_LETTER_GAP = 2'd2,
        REG_WORD_EXTRA = 2'd3
    } reg_index_t;

    localparam logic [UNIT_W-1:0] DOT_RESET        = 4'd1;
    localparam logic [UNIT_W-1:0] DASH_RESET       = 4'd3;
    localparam logic [UNIT_W-1:0] LETTER_GAP_RESET = 4'd3;
    localparam logic [UNIT_W-1:0] WORD_EXTRA_RESET = 4'd4;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // per-character plan: index of the final segment, symbol bits, space flag
    typedef struct packed {
        logic [SEG_W-1:0] last_seg;
        logic [3:0]       sym_bits;
        logic             is_space;
    } char_plan_t;

    // number of symbols of each letter
    function automatic logic [2:0] sym_count(input logic [4:0] idx);
        logic [2:0] n;
        case (idx)
            5'd4, 5'd19:                                   n = 3'd1;
            5'd0, 5'd8, 5'd12, 5'd13:                      n = 3'd2;
            5'd3, 5'd6, 5'd10, 5'd14, 5'd17, 5'd18,
            5'd20, 5'd22:                                  n = 3'd3;
            5'd1, 5'd2, 5'd5, 5'd7, 5'd9, 5'd11, 5'd15,
            5'd16, 5'd21, 5'd23, 5'd24, 5'd25:             n = 3'd4;
            default:                                       n = 3'd1;
        endcase
        return n;
    endfunction

    // symbol pattern, first symbol in bit 0, set bit is a dash
    function automatic logic [3:0] sym_pattern(input logic [4:0] idx);
        logic [3:0] b;
        case (idx)
            5'd0:  b = 4'd2;
            5'd1:  b = 4'd1;
            5'd2:  b = 4'd5;
            5'd3:  b = 4'd1;
            5'd4:  b = 4'd0;
            5'd5:  b = 4'd4;
            5'd6:  b = 4'd3;
            5'd7:  b = 4'd0;
            5'd8:  b = 4'd0;
            5'd9:  b = 4'd14;
            5'd10: b = 4'd5;
            5'd11: b = 4'd2;
            5'd12: b = 4'd3;
            5'd13: b = 4'd1;
            5'd14: b = 4'd7;
            5'd15: b = 4'd6;
            5'd16: b = 4'd11;
            5'd17: b = 4'd2;
            5'd18: b = 4'd0;
            5'd19: b = 4'd1;
            5'd20: b = 4'd4;
            5'd21: b = 4'd8;
            5'd22: b = 4'd6;
            5'd23: b = 4'd9;
            5'd24: b = 4'd13;
            5'd25: b = 4'd3;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/mle_decode.sv =====
// character decoder: turns a character code into its segment plan
module mle_decode (
    input  logic [mle_pkg::CHAR_W-1:0] char_code,
    output mle_pkg::char_plan_t        plan
);

    logic [4:0] letter_idx;
    logic       is_letter;
    logic [2:0] n_sym;

    always_comb
    begin
        is_letter  = 1'b0;
        letter_idx = 5'd0;
        if (char_code inside {[mle_pkg::CHAR_UPPER_A:mle_pkg::CHAR_UPPER_Z]})
        begin
            is_letter  = 1'b1;
            letter_idx = 5'(char_code - mle_pkg::CHAR_UPPER_A);
        end
        else if (char_code inside {[mle_pkg::CHAR_LOWER_A:mle_pkg::CHAR_LOWER_Z]})
        begin
            is_letter  = 1'b1;
            letter_idx = 5'(char_code - mle_pkg::CHAR_LOWER_A);
        end
    end

    assign n_sym = mle_pkg::sym_count(letter_idx);

    always_comb
    begin
        plan.sym_bits = mle_pkg::sym_pattern(letter_idx);
        plan.is_space = 1'b0;
        if (is_letter)
        begin
            // symbols and inner gaps, then the letter gap
            plan.last_seg = mle_pkg::SEG_W'({1'b0, n_sym, 1'b0} - 5'd1);
        end
        else if (char_code == mle_pkg::CHAR_SPACE)
        begin
            plan.last_seg = mle_pkg::SEG_W'(1);
            plan.is_space = 1'b1;
        end
        else
        begin
            plan.last_seg = '0;
        end
    end

endmodule

// ===== hdl/morse_letter_encoder.sv =====
// morse letter encoder top level: request register, segment sequencer, output register
//
// input channel: in_valid / in_stall with char_code, one character per request
// output channel: out_valid / out_stall with led_level, duration_units and
// last_segment, one segment per request, last_segment set on the final one
// a letter of n symbols gives 2n segments, a space two, any other code one
// a taken character is registered with its plan; its first segment then moves into
// the output register; throughput: one segment per cycle unless out_stall holds,
// 1 to 8 segments per character; the next character is taken in the cycle its
// predecessor's final segment moves into the output register, so characters follow
// with no idle cycle; timing registers are written via wr_en / wr_index / wr_data;
// the user is to write them only while idle, which the block does not enforce
// reset: channels empty, timing registers at dot 1, dash 3, letter gap 3,
// word extra 4
// out_stall holds the output register; the held character then waits and
// in_stall stays high until its last segment has moved on
module morse_letter_encoder (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              wr_en,
    input  logic [mle_pkg::REG_W-1:0]         wr_index,
    input  logic [mle_pkg::UNIT_W-1:0]        wr_data,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mle_pkg::CHAR_W-1:0]        char_code,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              led_level,
    output logic [mle_pkg::UNIT_W-1:0]        duration_units,
    output logic                              last_segment
);

    logic [mle_pkg::UNIT_W-1:0] dot_reg;
    logic [mle_pkg::UNIT_W-1:0] dash_reg;
    logic [mle_pkg::UNIT_W-1:0] letter_gap_reg;
    logic [mle_pkg::UNIT_W-1:0] word_extra_reg;

    mle_pkg::char_plan_t        dec_plan;
    mle_pkg::char_plan_t        plan_reg;
    logic                       cur_valid_reg;
    logic                       cur_valid_next;
    logic [mle_pkg::SEG_W-1:0]  seg_reg;
    logic [mle_pkg::SEG_W-1:0]  seg_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       level_reg;
    logic [mle_pkg::UNIT_W-1:0] dur_reg;
    logic                       last_reg;

    logic                       load_out;
    logic                       cur_done;
    logic                       accept;
    logic                       seg_level;
    logic [mle_pkg::UNIT_W-1:0] seg_dur;
    logic                       seg_last;

    mle_decode u_decode (
        .char_code (char_code),
        .plan      (dec_plan)
    );

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg        <= mle_pkg::DOT_RESET;
            dash_reg       <= mle_pkg::DASH_RESET;
            letter_gap_reg <= mle_pkg::LETTER_GAP_RESET;
            word_extra_reg <= mle_pkg::WORD_EXTRA_RESET;
        end
        else if (wr_en)
        begin
            case (mle_pkg::reg_index_t'(wr_index))
                mle_pkg::REG_DOT:        dot_reg        <= wr_data;
                mle_pkg::REG_DASH:       dash_reg       <= wr_data;
                mle_pkg::REG_LETTER_GAP: letter_gap_reg <= wr_data;
                mle_pkg::REG_WORD_EXTRA: word_extra_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // segment selection for the current index
    always_comb
    begin
        seg_last  = (seg_reg == plan_reg.last_seg);
        seg_level = 1'b0;
        seg_dur   = letter_gap_reg;
        if (!seg_last)
        begin
            if (plan_reg.is_space)
            begin
                seg_dur = word_extra_reg;
            end
            else if (seg_reg[0])
            begin
                seg_dur = dot_reg;
            end
            else
            begin
                seg_level = 1'b1;
                seg_dur   = plan_reg.sym_bits[seg_reg[2:1]] ? dash_reg : dot_reg;
            end
        end
    end

    assign load_out = cur_valid_reg && (!out_valid_reg || !out_stall);
    assign cur_done = load_out && seg_last;
    assign in_stall = cur_valid_reg && !cur_done;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        seg_next       = seg_reg;
        if (accept)
        begin
            cur_valid_next = 1'b1;
            seg_next       = '0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (load_out)
        begin
            seg_next = seg_reg + mle_pkg::SEG_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg <= dec_plan;
        end
        if (load_out)
        begin
            level_reg <= seg_level;
            dur_reg   <= seg_dur;
            last_reg  <= seg_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_level      = level_reg;
    assign duration_units = dur_reg;
    assign last_segment   = last_reg;

endmodule
